>>> design/u2n_pkg.sv
// Shared types, codes and table sizes for the Unicode to narrow charset converter.
`timescale 1ns / 1ps
package u2n_pkg;

  // Byte table depth; kept a power of two so the index wraps by truncation
  localparam int TABLE_DEPTH = 8192;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);
  localparam int PAGE_DEPTH  = 256;
  localparam int PAGE_AW     = $clog2(PAGE_DEPTH);
  localparam int LOAD_AW     = 13;

  typedef enum logic [1:0] {
    OP_LOAD_PAGE = 2'd0,
    OP_LOAD_CHAR = 2'd1,
    OP_CODE_UNIT = 2'd2,
    OP_LONE_BYTE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CONVERT = 2'd1,
    ST_TRUNC   = 2'd2,
    ST_BADIN   = 2'd3
  } status_t;

  // One source word in flight between table lookups
  typedef struct packed {
    logic        lone;
    logic [15:0] code_unit;
    logic        run_start;
    logic [15:0] out_capacity;
    logic        run_last;
  } stage_t;

endpackage

>>> design/u2n_if.sv
// Channel interfaces: source words, result words and configuration writes.
`timescale 1ns / 1ps
interface u2n_in_if;
  import u2n_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [LOAD_AW-1:0] load_addr;
  logic [15:0]        load_value;
  logic [15:0]        code_unit;
  logic               run_start;
  logic [15:0]        out_capacity;
  logic               run_last;
  modport source (output valid, op, load_addr, load_value, code_unit, run_start,
                  out_capacity, run_last, input ready);
  modport sink (input valid, op, load_addr, load_value, code_unit, run_start,
                out_capacity, run_last, output ready);
endinterface

interface u2n_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic [1:0]  status;
  logic        run_done;
  logic [15:0] consumed_bytes;
  logic [15:0] produced_bytes;
  modport source (output valid, out_byte, byte_valid, status, run_done,
                  consumed_bytes, produced_bytes, input ready);
  modport sink (input valid, out_byte, byte_valid, status, run_done,
                consumed_bytes, produced_bytes, output ready);
endinterface

interface u2n_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> design/unicode_to_narrow_charset.sv
// Top level: two-level table lookup converting 16-bit code units to narrow bytes.
// Path: a source word's result passes the page table read, the byte table read, then
//   the counter update into the output register.
// Throughput: one word per cycle unless results stall; only run state carries over.
// Load words write the tables in their accept cycle and give no result.
// Reset clears the run counters, stop flag, status, pipeline valids and the
//   unmappable code; table contents are undefined until loaded (no clearing pass).
`timescale 1ns / 1ps
module unicode_to_narrow_charset (
  input logic clk,
  input logic rst,
  u2n_cfg_if.sink   cfg,
  u2n_in_if.sink    items,
  u2n_out_if.source results
);
  import u2n_pkg::*;

  // Table memories
  logic [15:0] page_mem [PAGE_DEPTH];
  logic [7:0]  char_mem [TABLE_DEPTH];

  logic [7:0] unmappable_code;

  // Pipeline registers
  logic        v1, v2;
  stage_t      s1, s2;
  logic [15:0] page_q;
  logic [7:0]  char_q;

  // Run state
  logic [15:0] capacity_left, consumed_count, produced_count;
  logic        run_stopped;
  status_t     run_status;

  // Output register
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        byte_valid;
  status_t     out_status;
  logic        out_done;
  logic [15:0] out_consumed, out_produced;

  // Stage enables: a stage moves when the one ahead moves or it holds a bubble
  logic en_out, en2, en1, accept;
  assign en_out = !out_valid || results.ready;
  assign en2    = en_out || !v2;
  assign en1    = en2 || !v1;
  assign items.ready = en1;
  assign accept = items.valid && en1;

  // Configuration register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      unmappable_code <= 8'd0;
    end else if (cfg.valid) begin
      unmappable_code <= cfg.data;
    end
  end

  // Load decode and table index for byte loads
  op_t                        in_op;
  logic [LOAD_AW+TBL_AW-1:0]  load_wide;
  logic [TBL_AW-1:0]          load_idx;
  logic                       is_source;
  assign in_op     = op_t'(items.op);
  assign load_wide = (LOAD_AW + TBL_AW)'(items.load_addr);
  assign load_idx  = load_wide[TBL_AW-1:0];
  always_comb begin
    unique case (in_op)
      OP_LOAD_PAGE: is_source = 1'b0;
      OP_LOAD_CHAR: is_source = 1'b0;
      OP_CODE_UNIT: is_source = 1'b1;
      OP_LONE_BYTE: is_source = 1'b1;
      default:      is_source = 1'b0;
    endcase
  end

  // Page table: written by page loads, read with the accepted word's high byte
  always_ff @(posedge clk) begin
    if (accept && in_op == OP_LOAD_PAGE) begin
      page_mem[items.load_addr[PAGE_AW-1:0]] <= items.load_value;
    end
    if (en1) begin
      page_q <= page_mem[items.code_unit[15:8]];
    end
  end

  // Stage 1 word
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= accept && is_source;
    end
  end
  always_ff @(posedge clk) begin
    if (en1) begin
      s1.lone         <= (in_op == OP_LONE_BYTE);
      s1.code_unit    <= items.code_unit;
      s1.run_start    <= items.run_start;
      s1.out_capacity <= items.out_capacity;
      s1.run_last     <= items.run_last;
    end
  end

  // Byte table index: page offset plus low byte, wrapping at the table depth
  logic [16:0]       char_sum;
  logic [TBL_AW-1:0] char_addr;
  assign char_sum  = 17'(page_q) + 17'(s1.code_unit[7:0]);
  assign char_addr = char_sum[TBL_AW-1:0];

  // Byte table: a read in the same cycle as a load returns the old byte,
  // which is right since the load came later in the stream
  always_ff @(posedge clk) begin
    if (accept && in_op == OP_LOAD_CHAR) begin
      char_mem[load_idx] <= items.load_value[7:0];
    end
    if (en2) begin
      char_q <= char_mem[char_addr];
    end
  end

  // Stage 2 word
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (en2) begin
      s2 <= s1;
    end
  end

  // Run update: apply run start, then stop checks or emit
  logic [15:0] cap_e, cons_e, prod_e;
  logic        stop_e;
  status_t     stat_e;
  logic [15:0] capacity_left_next, consumed_count_next, produced_count_next;
  logic        run_stopped_next;
  status_t     run_status_next;
  logic        emit;
  always_comb begin
    if (s2.run_start) begin
      cap_e  = s2.out_capacity;
      cons_e = 16'd0;
      prod_e = 16'd0;
      stop_e = 1'b0;
      stat_e = ST_OK;
    end else begin
      cap_e  = capacity_left;
      cons_e = consumed_count;
      prod_e = produced_count;
      stop_e = run_stopped;
      stat_e = run_status;
    end
    capacity_left_next  = cap_e;
    consumed_count_next = cons_e;
    produced_count_next = prod_e;
    run_stopped_next    = stop_e;
    run_status_next     = stat_e;
    emit                = 1'b0;
    if (!stop_e) begin
      priority if (s2.lone) begin
        run_stopped_next = 1'b1;
        run_status_next  = ST_BADIN;
      end else if (cap_e == 16'd0) begin
        run_stopped_next = 1'b1;
        run_status_next  = ST_TRUNC;
      end else if (char_q == unmappable_code && s2.code_unit != {8'd0, unmappable_code}) begin
        run_stopped_next = 1'b1;
        run_status_next  = ST_CONVERT;
      end else begin
        emit                = 1'b1;
        consumed_count_next = cons_e + 16'd2;
        produced_count_next = prod_e + 16'd1;
        capacity_left_next  = cap_e - 16'd1;
      end
    end
  end

  // Run state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_left  <= 16'd0;
      consumed_count <= 16'd0;
      produced_count <= 16'd0;
      run_stopped    <= 1'b0;
      run_status     <= ST_OK;
    end else if (en_out && v2) begin
      capacity_left  <= capacity_left_next;
      consumed_count <= consumed_count_next;
      produced_count <= produced_count_next;
      run_stopped    <= run_stopped_next;
      run_status     <= run_status_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_out) begin
      out_valid <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (en_out) begin
      out_byte     <= emit ? char_q : 8'd0;
      byte_valid   <= emit;
      out_status   <= s2.run_last ? run_status_next : ST_OK;
      out_done     <= s2.run_last;
      out_consumed <= s2.run_last ? consumed_count_next : 16'd0;
      out_produced <= s2.run_last ? produced_count_next : 16'd0;
    end
  end

  assign results.valid          = out_valid;
  assign results.out_byte       = out_byte;
  assign results.byte_valid     = byte_valid;
  assign results.status         = out_status;
  assign results.run_done       = out_done;
  assign results.consumed_bytes = out_consumed;
  assign results.produced_bytes = out_produced;

  // Checks
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && out_valid && !results.ready) |-> !items.ready)
    else $error("accepted a word into a full stalled pipeline");

  a_emit_counts: assert property (@(posedge clk) disable iff (rst)
    (en_out && v2 && emit) |=> produced_count == $past(prod_e) + 16'd1)
    else $error("produced count did not advance on an emitted byte");

  a_emit_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && byte_valid && out_done) |-> out_status == ST_OK)
    else $error("byte emitted on a word ending a stopped run");

  a_not_done_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_done) |->
      (out_status == ST_OK && out_consumed == 16'd0 && out_produced == 16'd0))
    else $error("status or counts reported before run end");

endmodule

>>> verif/unicode_to_narrow_charset_test.sv
// Testbench for the Unicode to narrow charset converter: directed table, then random runs.
`timescale 1ns / 1ps
module unicode_to_narrow_charset_test;
  import u2n_pkg::*;

  localparam int WINDOW_LEN          = 24;
  localparam int PAGES_PER_WINDOW    = 8;
  localparam int RUN_ITEMS_PER_PHASE = 55;
  localparam int WRAP_RUN_LEN        = 12;
  localparam int DRAIN_CYCLES        = 8;
  localparam int N_DIRECTED          = 24;

  // One source word as driven on the item channel
  typedef struct packed {
    op_t                op;
    logic [LOAD_AW-1:0] load_addr;
    logic [15:0]        load_value;
    logic [15:0]        code_unit;
    logic               run_start;
    logic [15:0]        out_capacity;
    logic               run_last;
  } src_word_t;

  // One result word as seen on the result channel
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    status_t     status;
    logic        run_done;
    logic [15:0] consumed;
    logic [15:0] produced;
  } narrow_word_t;

  typedef struct packed {
    src_word_t    word;
    logic         typed;
    narrow_word_t want;
  } plan_row_t;

  localparam narrow_word_t NO_RESULT = '0;

  // Directed table, run with the sentinel at 8'hFF.
  // Page 0 -> offset 0, page FF -> offset FFFF (wraps to 8191, then 0).
  localparam plan_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // loads, with run flags set that must be ignored
    '{'{OP_LOAD_PAGE, 13'h1F00, 16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b1}, 1'b0, NO_RESULT},
    '{'{OP_LOAD_PAGE, 13'h00FF, 16'hFFFF, 16'h0000, 1'b0, 16'h0000, 1'b0}, 1'b0, NO_RESULT},
    '{'{OP_LOAD_CHAR, 13'h0000, 16'hFF41, 16'h0000, 1'b0, 16'h0000, 1'b0}, 1'b0, NO_RESULT},
    '{'{OP_LOAD_CHAR, 13'h1FFF, 16'h0042, 16'h0000, 1'b0, 16'h0000, 1'b0}, 1'b0, NO_RESULT},
    '{'{OP_LOAD_CHAR, 13'h00FF, 16'h00FF, 16'h0000, 1'b0, 16'h0000, 1'b0}, 1'b0, NO_RESULT},
    '{'{OP_LOAD_CHAR, 13'h0001, 16'h00FF, 16'h0000, 1'b0, 16'h0000, 1'b0}, 1'b0, NO_RESULT},
    '{'{OP_LOAD_CHAR, 13'h0002, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0}, 1'b0, NO_RESULT},
    // no run start since reset: capacity is zero
    '{'{OP_CODE_UNIT, 13'h0000, 16'h0000, 16'h0000, 1'b0, 16'hFFFF, 1'b1}, 1'b1,
      '{8'h00, 1'b0, ST_TRUNC, 1'b1, 16'd0, 16'd0}},
    // lone byte as a whole run
    '{'{OP_LONE_BYTE, 13'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0005, 1'b1}, 1'b1,
      '{8'h00, 1'b0, ST_BADIN, 1'b1, 16'd0, 16'd0}},
    // full capacity run ending on an unmappable byte
    '{'{OP_CODE_UNIT, 13'h0000, 16'h0000, 16'h0000, 1'b1, 16'hFFFF, 1'b0}, 1'b1,
      '{8'h41, 1'b1, ST_OK, 1'b0, 16'd0, 16'd0}},
    '{'{OP_CODE_UNIT, 13'h0000, 16'h0000, 16'hFF00, 1'b0, 16'h0000, 1'b0}, 1'b1,
      '{8'h42, 1'b1, ST_OK, 1'b0, 16'd0, 16'd0}},
    '{'{OP_CODE_UNIT, 13'h0000, 16'h0000, 16'hFF01, 1'b0, 16'h0000, 1'b0}, 1'b0, NO_RESULT},
    // sentinel byte reached from the sentinel code unit itself
    '{'{OP_CODE_UNIT, 13'h0000, 16'h0000, 16'h00FF, 1'b0, 16'h0000, 1'b0}, 1'b0, NO_RESULT},
    '{'{OP_CODE_UNIT, 13'h0000, 16'h0000, 16'h0001, 1'b0, 16'h0000, 1'b0}, 1'b0, NO_RESULT},
    '{'{OP_CODE_UNIT, 13'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b1}, 1'b0, NO_RESULT},
    // capacity runs out before the last unit
    '{'{OP_CODE_UNIT, 13'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0002, 1'b0}, 1'b0, NO_RESULT},
    '{'{OP_CODE_UNIT, 13'h0000, 16'h0000, 16'hFF00, 1'b0, 16'h0000, 1'b0}, 1'b0, NO_RESULT},
    '{'{OP_CODE_UNIT, 13'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b1}, 1'b0, NO_RESULT},
    // capacity used up exactly on the last unit
    '{'{OP_CODE_UNIT, 13'h0000, 16'h0000, 16'h0002, 1'b1, 16'h0001, 1'b1}, 1'b1,
      '{8'h00, 1'b1, ST_OK, 1'b1, 16'd2, 16'd1}},
    '{'{OP_CODE_UNIT, 13'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b1}, 1'b1,
      '{8'h00, 1'b0, ST_TRUNC, 1'b1, 16'd0, 16'd0}},
    // lone byte in mid-run, then a unit after the stop
    '{'{OP_CODE_UNIT, 13'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0003, 1'b0}, 1'b0, NO_RESULT},
    '{'{OP_LONE_BYTE, 13'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0}, 1'b0, NO_RESULT},
    '{'{OP_CODE_UNIT, 13'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b1}, 1'b0, NO_RESULT},
    // no run start after a stopped run: still stopped
    '{'{OP_CODE_UNIT, 13'h0000, 16'h0000, 16'hFF01, 1'b0, 16'h0000, 1'b1}, 1'b0, NO_RESULT}
  };

  localparam logic [7:0] SENTINELS [3] = '{8'h00, 8'h80, 8'hFF};

  logic clk;
  logic rst;

  u2n_cfg_if cfg_if ();
  u2n_in_if  items_if ();
  u2n_out_if results_if ();

  unicode_to_narrow_charset i_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_if),
    .items   (items_if),
    .results (results_if)
  );

  // Converter state mirror
  logic [15:0] page_offset [PAGE_DEPTH];
  logic [7:0]  char_byte   [TABLE_DEPTH];
  bit          page_loaded [PAGE_DEPTH];
  bit          char_loaded [TABLE_DEPTH];
  logic [7:0]  loaded_pages [$];
  logic [15:0] cap_left     = '0;
  logic [15:0] consumed_cnt = '0;
  logic [15:0] produced_cnt = '0;
  logic        run_halted   = 1'b0;
  status_t     halt_status  = ST_OK;
  logic [7:0]  unmappable   = '0;

  narrow_word_t      pending_bytes [$];
  int                error_count = 0;
  bit                tx_burst    = 1'b0;
  bit                rx_burst    = 1'b0;
  logic [TBL_AW-1:0] window_base = '0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Predict one source word; returns 1 when it yields a result word
  function automatic bit convert_word(input src_word_t w, output narrow_word_t res);
    logic [TBL_AW-1:0] idx;
    logic [7:0]        ch;
    res = '0;
    case (w.op)
      OP_LOAD_PAGE: begin
        if (!page_loaded[w.load_addr[7:0]]) loaded_pages.push_back(w.load_addr[7:0]);
        page_loaded[w.load_addr[7:0]] = 1'b1;
        page_offset[w.load_addr[7:0]] = w.load_value;
        return 1'b0;
      end
      OP_LOAD_CHAR: begin
        char_loaded[TBL_AW'(w.load_addr)] = 1'b1;
        char_byte[TBL_AW'(w.load_addr)]   = w.load_value[7:0];
        return 1'b0;
      end
      default: ;
    endcase
    if (w.run_start) begin
      cap_left     = w.out_capacity;
      consumed_cnt = '0;
      produced_cnt = '0;
      run_halted   = 1'b0;
      halt_status  = ST_OK;
    end
    if (!run_halted) begin
      if (w.op == OP_LONE_BYTE) begin
        run_halted  = 1'b1;
        halt_status = ST_BADIN;
      end else if (cap_left == 16'd0) begin
        run_halted  = 1'b1;
        halt_status = ST_TRUNC;
      end else begin
        idx = page_offset[w.code_unit[15:8]][TBL_AW-1:0] + TBL_AW'(w.code_unit[7:0]);
        ch  = char_byte[idx];
        if (ch == unmappable && w.code_unit != {8'h00, unmappable}) begin
          run_halted  = 1'b1;
          halt_status = ST_CONVERT;
        end else begin
          res.out_byte   = ch;
          res.byte_valid = 1'b1;
          consumed_cnt   = consumed_cnt + 16'd2;
          produced_cnt   = produced_cnt + 16'd1;
          cap_left       = cap_left - 16'd1;
        end
      end
    end
    if (w.run_last) begin
      res.status   = halt_status;
      res.run_done = 1'b1;
      res.consumed = consumed_cnt;
      res.produced = produced_cnt;
    end
    return 1'b1;
  endfunction

  // Code unit on a loaded page whose byte entry is loaded, when such a unit exists
  function automatic logic [15:0] pick_code_unit();
    logic [7:0]        pg;
    logic [TBL_AW-1:0] idx;
    int                hits;
    int                sel;
    if (loaded_pages.size() == 0) return 16'h0000;
    pg   = loaded_pages[$urandom_range(0, loaded_pages.size() - 1)];
    hits = 0;
    for (int lo = 0; lo < 256; lo++) begin
      idx = page_offset[pg][TBL_AW-1:0] + TBL_AW'(lo);
      if (char_loaded[idx]) hits++;
    end
    if (hits == 0) return {pg, 8'h00};
    sel = $urandom_range(0, hits - 1);
    for (int lo = 0; lo < 256; lo++) begin
      idx = page_offset[pg][TBL_AW-1:0] + TBL_AW'(lo);
      if (char_loaded[idx]) begin
        if (sel == 0) return {pg, 8'(lo)};
        sel--;
      end
    end
    return {pg, 8'h00};
  endfunction

  // Page offset landing on the current window for some low byte
  function automatic logic [15:0] offset_into_window();
    return 16'(window_base) - 16'($urandom_range(0, 255)) + {3'($urandom_range(0, 7)), 13'h0};
  endfunction

  function automatic src_word_t noisy_word();
    src_word_t w;
    w.op           = op_t'($urandom_range(0, 3));
    w.load_addr    = LOAD_AW'($urandom);
    w.load_value   = 16'($urandom);
    w.code_unit    = pick_code_unit();
    w.run_start    = 1'($urandom);
    w.out_capacity = 16'($urandom);
    w.run_last     = 1'($urandom);
    return w;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  task automatic send_word(input src_word_t w, input logic typed, input narrow_word_t want);
    int           gap;
    narrow_word_t res;
    gap = tx_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      items_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items_if.valid        <= 1'b1;
    items_if.op           <= w.op;
    items_if.load_addr    <= w.load_addr;
    items_if.load_value   <= w.load_value;
    items_if.code_unit    <= w.code_unit;
    items_if.run_start    <= w.run_start;
    items_if.out_capacity <= w.out_capacity;
    items_if.run_last     <= w.run_last;
    do @(posedge clk); while (!items_if.ready);
    if (convert_word(w, res)) pending_bytes.push_back(typed ? want : res);
  endtask

  // Hold off the sender until every result is back, then let the pipe settle
  task automatic wait_drained();
    items_if.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_unmappable(input logic [7:0] code);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= code;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    unmappable = code;
  endtask

  task automatic send_random_load();
    src_word_t w;
    w = noisy_word();
    if ($urandom_range(0, 2) == 0) begin
      w.op         = OP_LOAD_PAGE;
      w.load_value = offset_into_window();
    end else begin
      w.op = OP_LOAD_CHAR;
    end
    send_word(w, 1'b0, NO_RESULT);
  endtask

  // Fresh byte window with some sentinels, and pages pointing into it
  task automatic load_window();
    src_word_t w;
    window_base = TBL_AW'($urandom);
    for (int i = 0; i < WINDOW_LEN; i++) begin
      w           = noisy_word();
      w.op        = OP_LOAD_CHAR;
      w.load_addr = window_base + TBL_AW'(i);
      if (i == 0 || $urandom_range(0, 4) == 0) w.load_value[7:0] = unmappable;
      send_word(w, 1'b0, NO_RESULT);
    end
    // page 0 set so the sentinel code unit lands on a sentinel byte
    w                = noisy_word();
    w.op             = OP_LOAD_PAGE;
    w.load_addr[7:0] = 8'h00;
    w.load_value     = 16'(window_base) - 16'(unmappable) + {3'($urandom_range(0, 7)), 13'h0};
    send_word(w, 1'b0, NO_RESULT);
    for (int i = 0; i < PAGES_PER_WINDOW; i++) begin
      w            = noisy_word();
      w.op         = OP_LOAD_PAGE;
      w.load_value = offset_into_window();
      send_word(w, 1'b0, NO_RESULT);
    end
  endtask

  // Mostly well-formed run; sometimes no start, a lone byte or a load inside
  task automatic random_run(inout int issued);
    int          len;
    logic [15:0] cap;
    src_word_t   w;
    len = $urandom_range(1, 8);
    cap = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, len + 1));
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 11) == 0) send_random_load();
      w           = noisy_word();
      w.op        = ($urandom_range(0, 15) == 0) ? OP_LONE_BYTE : OP_CODE_UNIT;
      w.run_start = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
      if (w.run_start) w.out_capacity = cap;
      w.run_last  = (i == len - 1);
      send_word(w, 1'b0, NO_RESULT);
      issued++;
    end
  endtask

  // Result sink with random stalls
  initial begin : result_sink
    int           stall;
    narrow_word_t got;
    narrow_word_t want;
    results_if.ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        results_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      results_if.ready <= 1'b1;
      do @(posedge clk); while (!results_if.valid);
      got.out_byte   = results_if.out_byte;
      got.byte_valid = results_if.byte_valid;
      got.status     = status_t'(results_if.status);
      got.run_done   = results_if.run_done;
      got.consumed   = results_if.consumed_bytes;
      got.produced   = results_if.produced_bytes;
      if (pending_bytes.size() == 0) begin
        error_count++;
        $display("%0t: result word with none expected: expected nothing, got %h", $time, got);
      end else begin
        want = pending_bytes.pop_front();
        check_field("out_byte", 16'(want.out_byte), 16'(got.out_byte));
        check_field("byte_valid", 16'(want.byte_valid), 16'(got.byte_valid));
        check_field("status", 16'(want.status), 16'(got.status));
        check_field("run_done", 16'(want.run_done), 16'(got.run_done));
        check_field("consumed_bytes", want.consumed, got.consumed);
        check_field("produced_bytes", want.produced, got.produced);
      end
    end
  end

  // Stimulus
  initial begin : source_side
    int                issued;
    src_word_t         w;
    logic [7:0]        wrap_page;
    logic [TBL_AW-1:0] wrap_slot;
    rst                   <= 1'b1;
    cfg_if.valid          <= 1'b0;
    cfg_if.data           <= '0;
    items_if.valid        <= 1'b0;
    items_if.op           <= OP_LOAD_PAGE;
    items_if.load_addr    <= '0;
    items_if.load_value   <= '0;
    items_if.code_unit    <= '0;
    items_if.run_start    <= 1'b0;
    items_if.out_capacity <= '0;
    items_if.run_last     <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed table
    write_unmappable(8'hFF);
    for (int r = 0; r < N_DIRECTED; r++) begin
      send_word(DIRECTED_ROWS[r].word, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
    end

    // random phases, one sentinel setting each
    for (int p = 0; p < 4; p++) begin
      wait_drained();
      write_unmappable((p < 3) ? SENTINELS[p] : 8'($urandom));
      tx_burst = (p == 1);
      rx_burst = (p == 1);
      load_window();
      issued = 0;
      while (issued < RUN_ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 9) == 0) begin
          w    = noisy_word();
          w.op = $urandom_range(0, 1) ? OP_CODE_UNIT : OP_LONE_BYTE;
          send_word(w, 1'b0, NO_RESULT);
          issued++;
        end else begin
          random_run(issued);
        end
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
    end

    // one back-to-back run at full capacity on a single byte slot
    wait_drained();
    tx_burst = 1'b1;
    rx_burst = 1'b0;
    w                  = noisy_word();
    w.op               = OP_LOAD_CHAR;
    wrap_slot          = TBL_AW'(w.load_addr);
    w.load_value[7:0]  = unmappable ^ 8'h5A;
    send_word(w, 1'b0, NO_RESULT);
    w            = noisy_word();
    w.op         = OP_LOAD_PAGE;
    wrap_page    = w.load_addr[7:0];
    w.load_value = {3'($urandom_range(0, 7)), wrap_slot};
    send_word(w, 1'b0, NO_RESULT);
    for (int i = 0; i < WRAP_RUN_LEN; i++) begin
      w.op           = OP_CODE_UNIT;
      w.load_addr    = LOAD_AW'($urandom);
      w.load_value   = 16'($urandom);
      w.code_unit    = {wrap_page, 8'h00};
      w.run_start    = (i == 0);
      w.out_capacity = 16'hFFFF;
      w.run_last     = (i == WRAP_RUN_LEN - 1);
      send_word(w, 1'b0, NO_RESULT);
    end

    wait_drained();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hang guard
  initial begin : watchdog
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
